>>> sv/arp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

  // Table geometry
  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  // Function codes
  localparam logic FN_UPDATE = 1'b0;
  localparam logic FN_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_REFRESH = 3'd0;
  localparam logic [2:0] ST_FILL    = 3'd1;
  localparam logic [2:0] ST_REPLACE = 3'd2;
  localparam logic [2:0] ST_DROP    = 3'd3;
  localparam logic [2:0] ST_HIT     = 3'd4;
  localparam logic [2:0] ST_MISS    = 3'd5;

  // Request payload
  typedef struct packed {
    logic        func;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [2:0]  iface_num;
    logic [31:0] now_ms;
  } arp_in_t;

  // Response payload
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [47:0] mac_out;
  } arp_out_t;

  // One stored cache entry; stamp of zero means empty
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [2:0]  iface;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Outcome of one pass over the table
  typedef struct packed {
    logic        hit;
    idx_t        hit_idx;
    logic [47:0] hit_mac;
    logic        empty;
    idx_t        empty_idx;
    logic        old;
    idx_t        old_idx;
  } scan_res_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> sv/arp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module arp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/arp_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module arp_scan (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [31:0]        key_ip,
  input  wire logic [31:0]        now_ms,
  input  wire logic               stb,
  input  wire arp_pkg::idx_t      idx,
  input  wire arp_pkg::entry_t    entry,
  output arp_pkg::scan_res_t      res
);

  import arp_pkg::*;

  scan_res_t   acc;
  scan_res_t   acc_next;
  logic [31:0] best;
  logic [31:0] best_next;

  // Compare one entry per strobe: first address match, first empty slot,
  // and oldest stamp strictly below now (lowest index wins on ties)
  always_comb begin
    acc_next  = acc;
    best_next = best;
    if (start) begin
      acc_next  = '0;
      best_next = now_ms;
    end else if (stb) begin
      if (!acc.hit && entry.ip == key_ip) begin
        acc_next.hit     = 1'b1;
        acc_next.hit_idx = idx;
        acc_next.hit_mac = entry.mac;
      end
      if (!acc.empty && entry.stamp == 32'd0) begin
        acc_next.empty     = 1'b1;
        acc_next.empty_idx = idx;
      end
      if (entry.stamp < best) begin
        best_next        = entry.stamp;
        acc_next.old     = 1'b1;
        acc_next.old_idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    best <= best_next;
  end

  assign res = acc;

endmodule

`default_nettype wire

>>> sv/arp_cache_oldest_replace_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A request transfer starts a pass through S_SCAN and S_WAIT; S_DONE then sets rsp_valid.
// Requests are taken one at a time, each pass paced by the single RAM read
// port walking the table one entry per cycle through one shared compare unit.
// A waiting response does not hold off the next request; it stalls that request's write-back and response in S_DONE.
// Reset: synchronous, clears every entry's valid bit so the whole table reads as zeros
// (empty) at once; no clearing pass is needed.

module arp_cache_oldest_replace_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire arp_pkg::arp_in_t  req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output arp_pkg::arp_out_t      rsp
);

  import arp_pkg::*;

  state_t              state;
  state_t              state_next;
  arp_in_t             req_q;
  idx_t                addr;
  idx_t                addr_next;
  logic                rd_stb;
  idx_t                rd_idx;
  logic                rd_vld;
  logic [ENTRIES-1:0]  valid_bits;
  logic [ENTRY_W-1:0]  ram_q;
  entry_t              entry_rd;
  entry_t              entry_wr;
  scan_res_t           scan_res;
  logic                start;
  logic                rd_en;
  logic                wr_en;
  idx_t                wr_idx;
  logic                finish;
  arp_out_t            rsp_next;

  // Entries never written read as the reset value
  assign entry_rd = rd_vld ? entry_t'(ram_q) : '0;

  assign entry_wr.ip    = req_q.ip_addr;
  assign entry_wr.mac   = req_q.mac_addr;
  assign entry_wr.iface = req_q.iface_num;
  assign entry_wr.stamp = req_q.now_ms;

  arp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata(entry_wr),
    .re   (rd_en),
    .raddr(addr),
    .rdata(ram_q)
  );

  // Time limit for the oldest search is taken straight from the incoming transfer
  arp_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .key_ip(req_q.ip_addr),
    .now_ms(req.now_ms),
    .stb   (rd_stb),
    .idx   (rd_idx),
    .entry (entry_rd),
    .res   (scan_res)
  );

  // Sequencer: next state, RAM control and the decision at the end of the pass
  always_comb begin
    state_next = state;
    addr_next  = addr;
    req_ready  = (state == S_IDLE);
    start      = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = '0;
    finish     = 1'b0;
    rsp_next   = '0;

    // Decision from the completed pass
    if (req_q.func == FN_LOOKUP) begin
      if (scan_res.hit) begin
        rsp_next.status  = ST_HIT;
        rsp_next.slot    = 3'(scan_res.hit_idx);
        rsp_next.mac_out = scan_res.hit_mac;
      end else begin
        rsp_next.status = ST_MISS;
      end
    end else if (scan_res.hit) begin
      rsp_next.status = ST_REFRESH;
      rsp_next.slot   = 3'(scan_res.hit_idx);
      wr_idx          = scan_res.hit_idx;
    end else if (scan_res.empty) begin
      rsp_next.status = ST_FILL;
      rsp_next.slot   = 3'(scan_res.empty_idx);
      wr_idx          = scan_res.empty_idx;
    end else if (scan_res.old) begin
      rsp_next.status = ST_REPLACE;
      rsp_next.slot   = 3'(scan_res.old_idx);
      wr_idx          = scan_res.old_idx;
    end else begin
      rsp_next.status = ST_DROP;
    end

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          start      = 1'b1;
          addr_next  = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (addr == idx_t'(ENTRIES - 1)) begin
          state_next = S_WAIT;
        end else begin
          addr_next = addr + idx_t'(1);
        end
      end
      S_WAIT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          finish     = 1'b1;
          wr_en      = (req_q.func == FN_UPDATE) &&
                       (rsp_next.status != ST_DROP);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_stb     <= 1'b0;
      valid_bits <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_stb <= rd_en;
      if (wr_en) begin
        valid_bits[wr_idx] <= 1'b1;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr   <= addr_next;
    rd_idx <= addr;
    if (rd_en) begin
      rd_vld <= valid_bits[addr];
    end
    if (start) begin
      req_q <= req;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/arp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module arp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire arp_pkg::arp_in_t  req,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire arp_pkg::arp_out_t rsp
);

  import arp_pkg::*;

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // One request at a time: busy right after a request transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // Only a hit carries a MAC
  a_mac_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_HIT |-> rsp.mac_out == 48'd0)
    else $error("MAC returned without a hit");

  // Dropped updates and misses point at no slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_DROP || rsp.status == ST_MISS)
      |-> rsp.slot == 3'd0)
    else $error("slot set on drop or miss");

endmodule

bind arp_cache_oldest_replace_top arp_checker u_chk (.*);

`default_nettype wire

>>> verif/tb_arp_cache_oldest_replace_top.sv
`timescale 1ns / 1ps

module tb_arp_cache_oldest_replace_top;
  import arp_pkg::*;

  localparam int POOL_SIZE    = 12;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3);

  // Shadow copy of the cache plus the replies it owes, in request order
  class arp_shadow_table;
    logic [31:0] ip    [ENTRIES];
    logic [47:0] mac   [ENTRIES];
    logic [2:0]  iface [ENTRIES];
    logic [31:0] stamp [ENTRIES];
    arp_out_t    due_replies [$];
    int          errors;
    int          replies_seen;
    int          status_seen [8];

    function new();
      foreach (ip[k]) begin
        ip[k]    = '0;
        mac[k]   = '0;
        iface[k] = '0;
        stamp[k] = '0;
      end
      foreach (status_seen[s]) status_seen[s] = 0;
      errors       = 0;
      replies_seen = 0;
    endfunction

    function void store(int k, arp_in_t r);
      ip[k]    = r.ip_addr;
      mac[k]   = r.mac_addr;
      iface[k] = r.iface_num;
      stamp[k] = r.now_ms;
    endfunction

    // Apply one request to the shadow table and return the reply it earns
    function arp_out_t resolve(arp_in_t r);
      arp_out_t    o;
      bit          done;
      bit          found;
      int          pick;
      logic [31:0] best;
      o.status  = ST_DROP;
      o.slot    = '0;
      o.mac_out = '0;
      done      = 1'b0;
      found     = 1'b0;
      pick      = 0;
      best      = r.now_ms;
      if (r.func == FN_LOOKUP) begin
        // empty entries take part in the compare too
        o.status = ST_MISS;
        for (int k = 0; k < ENTRIES && !done; k++) begin
          if (ip[k] == r.ip_addr) begin
            o.status  = ST_HIT;
            o.slot    = 3'(k);
            o.mac_out = mac[k];
            done      = 1'b1;
          end
        end
      end else begin
        for (int k = 0; k < ENTRIES && !done; k++) begin
          if (ip[k] == r.ip_addr) begin
            store(k, r);
            o.status = ST_REFRESH;
            o.slot   = 3'(k);
            done     = 1'b1;
          end
        end
        for (int k = 0; k < ENTRIES && !done; k++) begin
          if (stamp[k] == '0) begin
            store(k, r);
            o.status = ST_FILL;
            o.slot   = 3'(k);
            done     = 1'b1;
          end
        end
        // oldest strictly below now, lowest index wins a tie
        if (!done) begin
          for (int k = 0; k < ENTRIES; k++) begin
            if (stamp[k] < best) begin
              best  = stamp[k];
              pick  = k;
              found = 1'b1;
            end
          end
          if (found) begin
            store(pick, r);
            o.status = ST_REPLACE;
            o.slot   = 3'(pick);
          end
        end
      end
      return o;
    endfunction

    function void note_request(arp_in_t r);
      due_replies.push_back(resolve(r));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH reply %0d at %0t: %s", replies_seen, $realtime, msg);
      errors++;
    endtask

    task check_reply(arp_out_t got);
      arp_out_t want;
      replies_seen++;
      if (due_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing outstanding: %p", got));
        return;
      end
      want = due_replies.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
      if (got.mac_out !== want.mac_out)
        report_mismatch($sformatf("mac_out %h, want %h", got.mac_out, want.mac_out));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  arp_in_t   req       = '0;
  logic      rsp_ready = 1'b0;
  logic      req_ready;
  logic      rsp_valid;
  arp_out_t  rsp;

  arp_shadow_table shadow;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_left = 0;
  int          requests_sent = 0;
  logic [31:0] ip_pool [POOL_SIZE];
  logic [31:0] wall_ms;

  arp_cache_oldest_replace_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reply side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) shadow.check_reply(rsp);
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic arp_in_t make_req(logic fn, logic [31:0] a, logic [47:0] m,
                                       logic [2:0] f, logic [31:0] t);
    arp_in_t r;
    r.func      = fn;
    r.ip_addr   = a;
    r.mac_addr  = m;
    r.iface_num = f;
    r.now_ms    = t;
    return r;
  endfunction

  // Mostly a small address pool with a rising clock, so refreshes, hits,
  // replacements and drops all turn up; the rest is noise
  function automatic arp_in_t random_req();
    arp_in_t r;
    int      roll;
    if ($urandom_range(0, 49) == 0) ip_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
    r.func = ($urandom_range(0, 99) < 35) ? FN_LOOKUP : FN_UPDATE;
    roll = $urandom_range(0, 99);
    if (roll < 85) r.ip_addr = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (roll < 95) r.ip_addr = $urandom;
    else r.ip_addr = '0;
    r.mac_addr  = 48'({$urandom, $urandom});
    r.iface_num = 3'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      wall_ms  = wall_ms + $urandom_range(1, 2000);
      r.now_ms = wall_ms;
    end else if (roll < 92) begin
      r.now_ms = $urandom_range(0, wall_ms);
    end else if (roll < 95) begin
      r.now_ms = '0;
    end else if (roll < 97) begin
      r.now_ms = '1;
    end else begin
      r.now_ms = $urandom;
    end
    return r;
  endfunction

  // Offer one request and hold it until the transfer
  task automatic push_req(input arp_in_t item);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    shadow.note_request(item);
    requests_sent++;
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    repeat (count) push_req(random_req());
  endtask

  task automatic run_directed();
    // empty entry 0 matches address zero straight after reset
    push_req(make_req(FN_LOOKUP, 32'h0, 48'h0, 3'd0, 32'd5));
    push_req(make_req(FN_UPDATE, 32'h0, '1, 3'd7, 32'd100));
    push_req(make_req(FN_LOOKUP, 32'h0, 48'h0, 3'd0, 32'd101));
    // zero time leaves the slot marked empty, so the next update reuses it
    push_req(make_req(FN_UPDATE, '1, 48'h0, 3'd0, 32'd0));
    push_req(make_req(FN_UPDATE, 32'h0A00_0001, 48'h0011_2233_4455, 3'd1, 32'd200));
    push_req(make_req(FN_LOOKUP, '1, 48'h0, 3'd0, 32'd201));
    // fill the rest of the table
    for (int k = 2; k < ENTRIES; k++)
      push_req(make_req(FN_UPDATE, 32'h0A00_0000 + k, 48'({$urandom, $urandom}),
                        3'(k), 32'(100 * (k + 1))));
    // table full and nothing older than now
    push_req(make_req(FN_UPDATE, 32'hC0A8_0001, 48'h1, 3'd2, 32'd50));
    // replace the oldest, with time at its maximum
    push_req(make_req(FN_UPDATE, 32'hC0A8_0002, 48'h2, 3'd3, '1));
    // refresh to create a tie on the oldest stamp, lowest slot wins
    push_req(make_req(FN_UPDATE, 32'h0A00_0003, 48'h3, 3'd4, 32'd200));
    push_req(make_req(FN_UPDATE, 32'hC0A8_0003, 48'h4, 3'd5, 32'd1000));
    push_req(make_req(FN_LOOKUP, 32'h0A00_0003, 48'h0, 3'd0, 32'd1001));
    push_req(make_req(FN_LOOKUP, 32'h0A00_0001, 48'h0, 3'd0, 32'd1002));
    push_req(make_req(FN_UPDATE, 32'h0A00_0004, '1, 3'd7, '1));
    // equal stamp is not strictly older
    push_req(make_req(FN_UPDATE, 32'hC0A8_0004, 48'h5, 3'd6, 32'd200));
    push_req(make_req(FN_LOOKUP, 32'h0, 48'h0, 3'd0, 32'd1003));
    push_req(make_req(FN_LOOKUP, 32'hC0A8_0002, '1, 3'd7, '1));
  endtask

  initial begin
    shadow  = new();
    wall_ms = 32'd5000;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_phase(0, 0, 60);
    // long reply hold-off while requests keep coming
    rx_hold_left = LONG_HOLD;
    run_phase(0, 0, 40);
    run_phase(77, 0, 95);
    run_phase(0, 77, 95);
    run_phase(9, 9, 90);
    req_valid <= 1'b0;
    rx_stall_pct = 0;

    while (shadow.due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests sent, %0d replies checked, %0d mismatches",
             requests_sent, shadow.replies_seen, shadow.errors);
    $display("summary: refresh %0d fill %0d replace %0d drop %0d hit %0d miss %0d",
             shadow.status_seen[ST_REFRESH], shadow.status_seen[ST_FILL],
             shadow.status_seen[ST_REPLACE], shadow.status_seen[ST_DROP],
             shadow.status_seen[ST_HIT], shadow.status_seen[ST_MISS]);
    if (shadow.errors == 0 && shadow.due_replies.size() == 0) begin
      $display("tb_arp_cache_oldest_replace_top: done, clean");
    end else begin
      $display("tb_arp_cache_oldest_replace_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout: %0d replies still outstanding", shadow.due_replies.size());
    $display("tb_arp_cache_oldest_replace_top: done, errors");
    $finish;
  end

endmodule
